@@ sv/assert_macros.svh @@
// Assertion macros shared by the classifier RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATPC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("atpc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ATPC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("atpc: next-cycle check failed");

`endif

@@ sv/atpc_pkg.sv @@
package atpc_pkg;

  localparam int WINDOW  = 5;
  localparam int MED_IDX = (WINDOW - 1) / 2;
  localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int PIX_W   = 7;
  localparam int BASE_W  = 16;
  localparam int RATIO_W = 8;
  localparam int GAIN_W  = 9;
  localparam int FLOOR_W = 16;
  localparam int NEAR_W  = 11;
  localparam int DIST_W  = 12;
  localparam int PHASE_W = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [PIX_W-1:0]  WIN_RESET = 7'd20;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 9'd256;

  localparam logic CMD_PRIME    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  typedef enum logic [PHASE_W-1:0] {
    PH_NONE   = 3'd0,
    PH_NEAR   = 3'd1,
    PH_REFL   = 3'd2,
    PH_SHADOW = 3'd3,
    PH_CAUGHT = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CATCH_VALUE = 3'd0,
    CFG_CATCH_SAT   = 3'd1,
    CFG_DROP_RATIO  = 3'd2,
    CFG_BASE_FLOOR  = 3'd3,
    CFG_DARK_MEDIAN = 3'd4,
    CFG_NEAR_DIST   = 3'd5,
    CFG_GAIN        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic update;
  } base_ctrl_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PIX_W-1:0]   window_median;
  } result_t;

endpackage

@@ sv/atpc_ifs.sv @@
interface atpc_sample_if;
  import atpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [PIX_W-1:0]         lit_saturation;
  logic [PIX_W-1:0]         lit_value;
  logic [PIX_W-1:0]         ambient_saturation;
  logic [PIX_W-1:0]         ambient_value;
  logic [PIX_W-1:0]         reflectance;
  logic signed [DIST_W-1:0] range_reading;

  modport source (output valid, command, lit_saturation, lit_value, ambient_saturation,
                  ambient_value, reflectance, range_reading, input ready);
  modport sink (input valid, command, lit_saturation, lit_value, ambient_saturation,
                ambient_value, reflectance, range_reading, output ready);
endinterface

interface atpc_result_if;
  import atpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic [PIX_W-1:0]   window_median;

  modport source (output valid, phase, window_median, input ready);
  modport sink (input valid, phase, window_median, output ready);
endinterface

interface atpc_cfg_if;
  import atpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/atpc_cell.sv @@
module atpc_cell
  import atpc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift_en,
  input  logic [POS_W-1:0]            position,
  input  logic [WINDOW-1:0][PIX_W-1:0] next_window,
  output logic [PIX_W-1:0]            value,
  output logic                        med_sel
);

  logic [POS_W-1:0] rank;
  logic [PIX_W-1:0] own_next;

  assign own_next = next_window[position];

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= WIN_RESET;
    end else if (shift_en) begin
      value <= own_next;
    end
  end

  // Ties are broken by position so that the ranks form a permutation.
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((next_window[j] < own_next) ||
          ((next_window[j] == own_next) && (POS_W'(j) < position))) begin
        rank = rank + POS_W'(1);
      end
    end
  end

  assign med_sel = (rank == POS_W'(MED_IDX));

endmodule

@@ sv/atpc_window.sv @@
module atpc_window
  import atpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic [PIX_W-1:0] sample,
  output logic [PIX_W-1:0] median
);

  logic [WINDOW-1:0][PIX_W-1:0] cell_value;
  logic [WINDOW-1:0][PIX_W-1:0] next_window;
  logic [WINDOW-1:0]            med_sel;

  assign next_window[0] = sample;

  for (genvar i = 1; i < WINDOW; i++) begin : g_link
    assign next_window[i] = cell_value[i-1];
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    atpc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift_en    (shift_en),
      .position    (POS_W'(i)),
      .next_window (next_window),
      .value       (cell_value[i]),
      .med_sel     (med_sel[i])
    );
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (med_sel[i]) begin
        median = median | next_window[i];
      end
    end
  end

endmodule

@@ sv/atpc_baseline.sv @@
module atpc_baseline
  import atpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  base_ctrl_t         ctrl,
  input  logic [PIX_W-1:0]   sample,
  input  logic [RATIO_W-1:0] drop_ratio,
  input  logic [GAIN_W-1:0]  gain,
  output logic [BASE_W-1:0]  base,
  output logic               below
);

  logic [GAIN_W-1:0]         gain_sat;
  logic [23:0]               scaled_base;
  logic signed [16:0]        diff;
  logic signed [26:0]        prod;
  logic signed [27:0]        acc;
  logic [BASE_W-1:0]         base_next;

  assign scaled_base = base * drop_ratio;
  assign below       = {1'b0, sample, 16'h0000} < scaled_base;

  // new = base + g * ((x << 8) - base) / 256, rounded half up.
  assign gain_sat = (gain > GAIN_MAX) ? GAIN_MAX : gain;
  assign diff     = $signed({2'b00, sample, 8'h00}) - $signed({1'b0, base});
  assign prod     = $signed({1'b0, gain_sat}) * diff;
  assign acc      = $signed({4'h0, base, 8'h00}) + 28'(prod) + 28'sd128;

  always_comb begin
    base_next = base;
    if (ctrl.load) begin
      base_next = {1'b0, sample, 8'h00};
    end else if (ctrl.update) begin
      base_next = acc[23:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else begin
      base <= base_next;
    end
  end

endmodule

@@ sv/adaptive_target_presence_classifier_core.sv @@
// Adaptive target presence classifier.
// The samples channel carries one sample per transfer: a command bit (prime or
// classify), lit and ambient saturation and value, reflectance and a signed
// ultrasonic distance. The results channel returns exactly one transfer per
// sample, the detection phase and the window median.
// The cfg channel writes the seven threshold registers; it is always ready and
// should only be used while no sample is in flight.
// Each classify sample shifts its ambient value into a row of five window cells;
// the median of that row and both baseline trackers are worked out in the cycle
// of the transfer, so the baselines are ready for the next sample.
// Each result is registered in the output stage before it is offered.
// Throughput is one sample per cycle while samples.ready stays high.
// An output register backed by a one-entry skid buffer lets one more sample be
// taken while a result waits; with both full, samples.ready drops until the
// receiver takes a result.
// Synchronous reset restores register defaults, clears both baselines, fills
// the window with twenty and empties the output stage.
`include "assert_macros.svh"

module adaptive_target_presence_classifier_core
  import atpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  atpc_sample_if.sink   samples,
  atpc_result_if.source results,
  atpc_cfg_if.sink      cfg
);

  logic [PIX_W-1:0]   catch_value_max;
  logic [PIX_W-1:0]   catch_saturation_max;
  logic [RATIO_W-1:0] drop_ratio;
  logic [FLOOR_W-1:0] baseline_floor;
  logic [PIX_W-1:0]   dark_median_max;
  logic [NEAR_W-1:0]  near_distance_max;
  logic [GAIN_W-1:0]  smoothing_gain;

  logic               accept;
  logic               is_classify;
  logic               caught;
  logic               shadow_test;
  logic               confirmed;
  logic               near;
  logic               below_sat;
  logic               below_val;
  logic [BASE_W-1:0]  base_sat;
  logic [BASE_W-1:0]  base_value;
  logic [PIX_W-1:0]   median;
  base_ctrl_t         base_ctrl;
  result_t            result_next;

  result_t            out_data;
  logic               out_valid;
  result_t            skid_data;
  logic               skid_valid;
  logic               load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      catch_value_max      <= 7'd15;
      catch_saturation_max <= 7'd20;
      drop_ratio           <= 8'd102;
      baseline_floor       <= 16'd128;
      dark_median_max      <= 7'd10;
      near_distance_max    <= 11'd450;
      smoothing_gain       <= 9'd51;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_CATCH_VALUE: catch_value_max      <= cfg.data[PIX_W-1:0];
        CFG_CATCH_SAT:   catch_saturation_max <= cfg.data[PIX_W-1:0];
        CFG_DROP_RATIO:  drop_ratio           <= cfg.data[RATIO_W-1:0];
        CFG_BASE_FLOOR:  baseline_floor       <= cfg.data[FLOOR_W-1:0];
        CFG_DARK_MEDIAN: dark_median_max      <= cfg.data[PIX_W-1:0];
        CFG_NEAR_DIST:   near_distance_max    <= cfg.data[NEAR_W-1:0];
        CFG_GAIN:        smoothing_gain       <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = !skid_valid;
  assign accept        = samples.valid && samples.ready;
  assign is_classify   = (samples.command == CMD_CLASSIFY);

  atpc_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (accept && is_classify),
    .sample   (samples.ambient_value),
    .median   (median)
  );

  atpc_baseline u_base_sat (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (base_ctrl),
    .sample     (samples.ambient_saturation),
    .drop_ratio (drop_ratio),
    .gain       (smoothing_gain),
    .base       (base_sat),
    .below      (below_sat)
  );

  atpc_baseline u_base_value (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (base_ctrl),
    .sample     (samples.ambient_value),
    .drop_ratio (drop_ratio),
    .gain       (smoothing_gain),
    .base       (base_value),
    .below      (below_val)
  );

  assign caught = ((samples.lit_value != '0) && (samples.lit_value <= catch_value_max)) ||
                  ((samples.lit_saturation != '0) &&
                   (samples.lit_saturation <= catch_saturation_max));
  assign shadow_test = (below_sat || below_val) && (base_value > baseline_floor);
  assign confirmed   = shadow_test && (median <= dark_median_max);
  assign near = !samples.range_reading[DIST_W-1] && (samples.range_reading != '0) &&
                (samples.range_reading[NEAR_W-1:0] <= near_distance_max);

  assign base_ctrl.load   = accept && !is_classify;
  assign base_ctrl.update = accept && is_classify && !caught && !confirmed;

  always_comb begin
    result_next = '0;
    if (is_classify) begin
      if (caught) begin
        result_next.phase = PH_CAUGHT;
      end else if (shadow_test) begin
        result_next.phase         = confirmed ? PH_SHADOW : PH_NONE;
        result_next.window_median = median;
      end else if (samples.reflectance != '0) begin
        result_next.phase = PH_REFL;
      end else if (near) begin
        result_next.phase = PH_NEAR;
      end else begin
        result_next.phase = PH_NONE;
      end
    end
  end

  assign load = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= skid_valid ? skid_data : result_next;
    end else if (accept) begin
      skid_data <= result_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.phase         = out_data.phase;
  assign results.window_median = out_data.window_median;

  `ATPC_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  `ATPC_ASSERT_NXT(a_stall_to_skid, accept && out_valid && !results.ready, skid_valid)
  `ATPC_ASSERT_NXT(a_prime_loads, accept && !is_classify,
                   base_value == {1'b0, $past(samples.ambient_value), 8'h00})
  `ATPC_ASSERT_IMP(a_median_shadow_only, results.valid && (results.window_median != '0),
                   (results.phase == PH_SHADOW) || (results.phase == PH_NONE))

endmodule
